// ----- design/cmr_pkg.sv -----
// ----------------------------------------------------------------------------
// cmr_pkg
// Shared types and constants for the CAN multi-frame reassembler.
// ----------------------------------------------------------------------------
`default_nettype none

package cmr_pkg;

    localparam int SOURCE_SLOTS     = 4;
    localparam int FRAME_DATA_BYTES = 7;
    localparam int PACKET_BYTES     = 64;
    localparam int RING_DEPTH       = 8;

    localparam int ID_W    = 29;
    localparam int SLOT_W  = (SOURCE_SLOTS > 1) ? $clog2(SOURCE_SLOTS) : 1;
    localparam int PB_W    = $clog2(PACKET_BYTES);
    localparam int LEN_W   = $clog2(PACKET_BYTES + 1);
    localparam int RING_W  = $clog2(RING_DEPTH);
    localparam int K_W     = $clog2(FRAME_DATA_BYTES + 1);
    localparam int OFF_W   = $clog2(15 * FRAME_DATA_BYTES + FRAME_DATA_BYTES + 1);
    localparam int CNT_W   = LEN_W;  // copy counter, reaches PACKET_BYTES
    localparam int SUM_W   = 9;      // 127 + 255 + 127 fits
    localparam int CFG_W   = 29;
    localparam int CFG_IDX_W = 3;
    localparam int Q_DEPTH = 2;

    localparam logic [3:0] CNT_MASK  = 4'h0F;
    localparam int         IDX_SHIFT = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SRC_A   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_B   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_C   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_D   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LEN_POS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HDR     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CHK     = 3'd7;

    localparam logic OP_RECEIVE = 1'b0;
    localparam logic OP_POP     = 1'b1;

    typedef struct packed {
        logic             operation;
        logic [ID_W-1:0]  can_id;
        logic [7:0]       frame_header;
        logic [55:0]      frame_payload;
    } in_t;

    typedef struct packed {
        logic [7:0]       packet_byte;
        logic [LEN_W-1:0] packet_length;
        logic             last_byte;
        logic             ring_empty;
    } out_t;

    // classified request handed from front to back
    typedef struct packed {
        logic              operation;
        logic [SLOT_W-1:0] slot;
        logic [3:0]        fidx;
        logic [3:0]        fcnt;
        logic [55:0]       payload;
    } cmd_t;

    typedef struct packed {
        logic [LEN_W-1:0] header_bytes;
        logic [LEN_W-1:0] check_bytes;
        logic [5:0]       length_position;
    } fmt_cfg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_COPY,
        S_PLEN,
        S_PREAD,
        S_PEMIT,
        S_SPECIAL
    } state_t;

endpackage

`default_nettype wire

// ----- design/can_multiframe_reassembler_core.sv -----
// A receive passes the front register and the queue, then the back end stores its bytes
//   one at a time and, once a packet is complete, copies it into the ring.
// A pop fetches the length byte, then reads and emits each output byte in turn
//   (ring memory read, then output register); an empty pop gives a single marker result.
// Throughput is set by the back end, one request at a time; a 2-entry queue decouples it.
// Reset: asynchronous, active low; slots, ring pointers and registers return to defaults.
// ----------------------------------------------------------------------------
// can_multiframe_reassembler_core
// Reassembles segmented CAN messages per source and queues finished packets
// in a ring that is drained byte by byte on request.
// ----------------------------------------------------------------------------
`default_nettype none

module can_multiframe_reassembler_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire cmr_pkg::in_t                      in_data,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output cmr_pkg::out_t                          out_data,
    input  wire logic                              cfg_we,
    input  wire logic [cmr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [cmr_pkg::CFG_W-1:0]         cfg_data
);

    // configuration registers
    logic [cmr_pkg::SOURCE_SLOTS-1:0][cmr_pkg::ID_W-1:0] src_reg, src_next;
    logic [2:0]                 active_reg, active_next;
    cmr_pkg::fmt_cfg_t          fmt_reg, fmt_next;
    logic [2:0]                 active_sat;

    // front -> queue -> back
    logic          f_valid, f_ready, q_valid, q_ready;
    cmr_pkg::cmd_t f_cmd, q_cmd;

    always_comb
    begin
        src_next    = src_reg;
        active_next = active_reg;
        fmt_next    = fmt_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                cmr_pkg::REG_SRC_A:   src_next[0] = cfg_data[cmr_pkg::ID_W-1:0];
                cmr_pkg::REG_SRC_B:   src_next[1] = cfg_data[cmr_pkg::ID_W-1:0];
                cmr_pkg::REG_SRC_C:   src_next[2] = cfg_data[cmr_pkg::ID_W-1:0];
                cmr_pkg::REG_SRC_D:   src_next[3] = cfg_data[cmr_pkg::ID_W-1:0];
                cmr_pkg::REG_ACTIVE:  active_next = cfg_data[2:0];
                cmr_pkg::REG_LEN_POS: fmt_next.length_position = cfg_data[5:0];
                cmr_pkg::REG_HDR:     fmt_next.header_bytes = cfg_data[cmr_pkg::LEN_W-1:0];
                cmr_pkg::REG_CHK:     fmt_next.check_bytes = cfg_data[cmr_pkg::LEN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg                 <= '0;
            active_reg              <= 3'd0;
            fmt_reg.length_position <= 6'd1;
            fmt_reg.header_bytes    <= cmr_pkg::LEN_W'(4);
            fmt_reg.check_bytes     <= cmr_pkg::LEN_W'(2);
        end
        else
        begin
            src_reg    <= src_next;
            active_reg <= active_next;
            fmt_reg    <= fmt_next;
        end
    end

    // more active sources than slots saturates
    assign active_sat = (32'(active_reg) > cmr_pkg::SOURCE_SLOTS)
                        ? 3'(cmr_pkg::SOURCE_SLOTS) : active_reg;

    cmr_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .source_id      (src_reg),
        .active_sources (active_sat),
        .cmd_valid      (f_valid),
        .cmd_ready      (f_ready),
        .cmd            (f_cmd)
    );

    cmr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_cmd),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_cmd)
    );

    cmr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .fmt       (fmt_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// ----- design/cmr_front.sv -----
// ----------------------------------------------------------------------------
// cmr_front
// Matches the identifier against the source table and registers the request.
// ----------------------------------------------------------------------------
`default_nettype none

module cmr_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire cmr_pkg::in_t         in_data,
    input  wire logic [cmr_pkg::SOURCE_SLOTS-1:0][cmr_pkg::ID_W-1:0] source_id,
    input  wire logic [2:0]           active_sources,
    output logic                      cmd_valid,
    input  wire logic                 cmd_ready,
    output cmr_pkg::cmd_t             cmd
);

    logic           fv_reg, fv_next;
    cmr_pkg::cmd_t  cmd_reg, cmd_next;
    logic           hit;
    logic [cmr_pkg::SLOT_W-1:0] hit_slot;

    // first match among the active sources
    always_comb
    begin
        hit      = 1'b0;
        hit_slot = '0;
        for (int i = cmr_pkg::SOURCE_SLOTS - 1; i >= 0; i--)
        begin
            if ((32'(active_sources) > 32'(i)) && (source_id[i] == in_data.can_id))
            begin
                hit      = 1'b1;
                hit_slot = cmr_pkg::SLOT_W'(i);
            end
        end
    end

    assign in_ready = !fv_reg || cmd_ready;

    always_comb
    begin
        fv_next  = fv_reg;
        cmd_next = cmd_reg;
        if (fv_reg && cmd_ready)
        begin
            fv_next = 1'b0;
        end
        if (in_valid && in_ready)
        begin
            fv_next            = (in_data.operation == cmr_pkg::OP_POP) || hit;
            cmd_next.operation = in_data.operation;
            cmd_next.slot      = hit_slot;
            cmd_next.fidx      = 4'(in_data.frame_header >> cmr_pkg::IDX_SHIFT)
                                 & cmr_pkg::CNT_MASK;
            cmd_next.fcnt      = in_data.frame_header[3:0] & cmr_pkg::CNT_MASK;
            cmd_next.payload   = in_data.frame_payload;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= 1'b0;
        end
        else
        begin
            fv_reg <= fv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    assign cmd_valid = fv_reg;
    assign cmd       = cmd_reg;

endmodule

`default_nettype wire

// ----- design/cmr_queue.sv -----
// ----------------------------------------------------------------------------
// cmr_queue
// Two-entry request queue between the front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module cmr_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_valid,
    output logic               wr_ready,
    input  wire cmr_pkg::cmd_t wr_data,
    output logic               rd_valid,
    input  wire logic          rd_ready,
    output cmr_pkg::cmd_t      rd_data
);

    cmr_pkg::cmd_t  mem_reg [cmr_pkg::Q_DEPTH];
    logic           wp_reg, wp_next;
    logic           rp_reg, rp_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic           push, pop;

    assign wr_ready = (cnt_reg != 2'(cmr_pkg::Q_DEPTH));
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop  ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'(cmr_pkg::Q_DEPTH))
        else $error("queue count out of range");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'(cmr_pkg::Q_DEPTH)) && !pop |=> cnt_reg == 2'(cmr_pkg::Q_DEPTH))
        else $error("full queue changed without a pop");
    a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !push |=> cnt_reg == $past(cnt_reg) - 2'd1)
        else $error("pop not counted");

endmodule

`default_nettype wire

// ----- design/cmr_back.sv -----
// ----------------------------------------------------------------------------
// cmr_back
// Slot buffers, packet ring and the byte streamer for pops.
// ----------------------------------------------------------------------------
`default_nettype none

module cmr_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    output logic                   cmd_ready,
    input  wire cmr_pkg::cmd_t     cmd,
    input  wire cmr_pkg::fmt_cfg_t fmt,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output cmr_pkg::out_t          out_data
);

    localparam int S  = cmr_pkg::SOURCE_SLOTS;
    localparam int PB = cmr_pkg::PACKET_BYTES;
    localparam int RD = cmr_pkg::RING_DEPTH;

    cmr_pkg::state_t state_reg, state_next;

    logic [cmr_pkg::SLOT_W-1:0]   slot_reg, slot_next;
    logic [cmr_pkg::OFF_W-1:0]    off_reg, off_next;
    logic [55:0]                  payload_reg, payload_next;
    logic [cmr_pkg::K_W-1:0]      k_reg, k_next;
    logic [cmr_pkg::CNT_W-1:0]    c_reg, c_next;
    logic [3:0]                   exp_reg [S];
    logic [3:0]                   exp_next [S];
    logic [4:0]                   rcv_reg [S];
    logic [4:0]                   rcv_next [S];
    logic [S-1:0][PB-1:0]         valid_reg, valid_next;
    logic [cmr_pkg::RING_W-1:0]   head_reg, head_next, tail_reg, tail_next;
    logic [cmr_pkg::RING_W-1:0]   ptail_reg, ptail_next;
    logic                         lp_ok_reg, lp_ok_next;
    logic [cmr_pkg::LEN_W-1:0]    len_reg, len_next;
    logic [cmr_pkg::PB_W-1:0]     i_reg, i_next;
    logic                         empty_reg, empty_next;
    logic                         out_valid_reg, out_valid_next;
    cmr_pkg::out_t                out_reg, out_next;

    // memories and their read registers
    logic [7:0] slot_mem [S][PB];
    logic [7:0] ring_mem [RD][PB];
    logic [7:0] slot_rd_reg, ring_rd_reg;
    logic       sv_reg;

    logic                       slot_we, slot_re, ring_we, ring_re;
    logic [cmr_pkg::PB_W-1:0]   slot_wa, slot_ra, ring_wa, ring_ra;
    logic [7:0]                 slot_wd, ring_wd;
    logic [cmr_pkg::RING_W-1:0] ring_wrow, ring_rrow;

    logic                         out_free, full, ring_is_empty, last_k;
    logic [cmr_pkg::RING_W-1:0]   head_inc, tail_inc;
    logic [cmr_pkg::OFF_W-1:0]    waddr;
    logic [4:0]                   rcv_inc;
    logic [cmr_pkg::SUM_W-1:0]    sum;
    logic [cmr_pkg::LEN_W-1:0]    len_sat;
    logic                         dropped, complete;

    assign out_free      = !out_valid_reg || out_ready;
    assign head_inc      = (head_reg == cmr_pkg::RING_W'(RD - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc      = (tail_reg == cmr_pkg::RING_W'(RD - 1)) ? '0 : tail_reg + 1'b1;
    assign full          = (head_inc == tail_reg);
    assign ring_is_empty = (head_reg == tail_reg);
    assign waddr         = off_reg + cmr_pkg::OFF_W'(k_reg);
    assign last_k        = (k_reg == cmr_pkg::K_W'(cmr_pkg::FRAME_DATA_BYTES - 1));
    assign rcv_inc       = rcv_reg[slot_reg] + 5'd1;
    assign complete      = (rcv_inc == {1'b0, exp_reg[slot_reg]});
    assign dropped       = (cmd.fidx != 4'd0) && ({1'b0, cmd.fidx} != rcv_reg[cmd.slot]);
    assign sum = cmr_pkg::SUM_W'(fmt.header_bytes) + cmr_pkg::SUM_W'(fmt.check_bytes)
               + cmr_pkg::SUM_W'(lp_ok_reg ? ring_rd_reg : 8'd0);
    assign len_sat = (sum > cmr_pkg::SUM_W'(PB)) ? cmr_pkg::LEN_W'(PB)
                                                 : cmr_pkg::LEN_W'(sum);
    assign cmd_ready = (state_reg == cmr_pkg::S_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cmr_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.operation == cmr_pkg::OP_POP)
                    begin
                        state_next = ring_is_empty ? cmr_pkg::S_SPECIAL : cmr_pkg::S_PLEN;
                    end
                    else if (!dropped)
                    begin
                        state_next = cmr_pkg::S_WRITE;
                    end
                end
            end
            cmr_pkg::S_WRITE:
            begin
                if (last_k)
                begin
                    state_next = (complete && !full) ? cmr_pkg::S_COPY : cmr_pkg::S_IDLE;
                end
            end
            cmr_pkg::S_COPY:
            begin
                if (c_reg == cmr_pkg::CNT_W'(PB))
                begin
                    state_next = cmr_pkg::S_IDLE;
                end
            end
            cmr_pkg::S_PLEN:
            begin
                state_next = (len_sat == '0) ? cmr_pkg::S_SPECIAL : cmr_pkg::S_PREAD;
            end
            cmr_pkg::S_PREAD:
            begin
                state_next = cmr_pkg::S_PEMIT;
            end
            cmr_pkg::S_PEMIT:
            begin
                if (out_free)
                begin
                    state_next = (cmr_pkg::LEN_W'(i_reg) + 1'b1 == len_reg)
                                 ? cmr_pkg::S_IDLE : cmr_pkg::S_PREAD;
                end
            end
            cmr_pkg::S_SPECIAL:
            begin
                if (out_free)
                begin
                    state_next = cmr_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = cmr_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        slot_next      = slot_reg;
        off_next       = off_reg;
        payload_next   = payload_reg;
        k_next         = k_reg;
        c_next         = c_reg;
        exp_next       = exp_reg;
        rcv_next       = rcv_reg;
        valid_next     = valid_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        ptail_next     = ptail_reg;
        lp_ok_next     = lp_ok_reg;
        len_next       = len_reg;
        i_next         = i_reg;
        empty_next     = empty_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        slot_we        = 1'b0;
        slot_wa        = waddr[cmr_pkg::PB_W-1:0];
        slot_wd        = 8'(payload_reg >> {k_reg, 3'b000});
        slot_re        = 1'b0;
        slot_ra        = c_reg[cmr_pkg::PB_W-1:0];
        ring_we        = 1'b0;
        ring_wrow      = head_reg;
        ring_wa        = cmr_pkg::PB_W'(c_reg - 1'b1);
        ring_wd        = sv_reg ? slot_rd_reg : 8'd0;
        ring_re        = 1'b0;
        ring_rrow      = ptail_reg;
        ring_ra        = i_reg;
        case (state_reg)
            cmr_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    slot_next    = cmd.slot;
                    off_next     = cmr_pkg::OFF_W'(cmd.fidx) *
                                   cmr_pkg::OFF_W'(cmr_pkg::FRAME_DATA_BYTES);
                    payload_next = cmd.payload;
                    k_next       = '0;
                    if (cmd.operation == cmr_pkg::OP_POP)
                    begin
                        empty_next = ring_is_empty;
                        ptail_next = tail_reg;
                        lp_ok_next = (32'(fmt.length_position) < PB);
                        ring_re    = !ring_is_empty;
                        ring_rrow  = tail_reg;
                        ring_ra    = cmr_pkg::PB_W'(fmt.length_position);
                    end
                    else if (cmd.fidx == 4'd0 || dropped)
                    begin
                        // new packet or out-of-order frame: start over
                        valid_next[cmd.slot] = '0;
                        exp_next[cmd.slot]   = dropped ? 4'd0 : cmd.fcnt;
                        rcv_next[cmd.slot]   = 5'd0;
                    end
                end
            end
            cmr_pkg::S_WRITE:
            begin
                k_next = k_reg + 1'b1;
                if (waddr < cmr_pkg::OFF_W'(PB))
                begin
                    slot_we = 1'b1;
                    valid_next[slot_reg][waddr[cmr_pkg::PB_W-1:0]] = 1'b1;
                end
                if (last_k)
                begin
                    rcv_next[slot_reg] = rcv_inc;
                    c_next             = '0;
                    if (complete && full)
                    begin
                        valid_next[slot_reg] = '0;
                        exp_next[slot_reg]   = 4'd0;
                        rcv_next[slot_reg]   = 5'd0;
                    end
                end
            end
            cmr_pkg::S_COPY:
            begin
                c_next  = c_reg + 1'b1;
                slot_re = (c_reg < cmr_pkg::CNT_W'(PB));
                ring_we = (c_reg != '0);
                if (c_reg == cmr_pkg::CNT_W'(PB))
                begin
                    head_next            = head_inc;
                    valid_next[slot_reg] = '0;
                    exp_next[slot_reg]   = 4'd0;
                    rcv_next[slot_reg]   = 5'd0;
                end
            end
            cmr_pkg::S_PLEN:
            begin
                len_next   = len_sat;
                tail_next  = tail_inc;
                i_next     = '0;
                empty_next = 1'b0;
            end
            cmr_pkg::S_PREAD:
            begin
                ring_re = 1'b1;
            end
            cmr_pkg::S_PEMIT:
            begin
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_next.packet_byte   = ring_rd_reg;
                    out_next.packet_length = len_reg;
                    out_next.last_byte     = (cmr_pkg::LEN_W'(i_reg) + 1'b1 == len_reg);
                    out_next.ring_empty    = 1'b0;
                    i_next                 = i_reg + 1'b1;
                end
            end
            cmr_pkg::S_SPECIAL:
            begin
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_next.packet_byte   = 8'd0;
                    out_next.packet_length = '0;
                    out_next.last_byte     = 1'b1;
                    out_next.ring_empty    = empty_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cmr_pkg::S_IDLE;
            valid_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int s = 0; s < S; s++)
            begin
                exp_reg[s] <= 4'd0;
                rcv_reg[s] <= 5'd0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            out_valid_reg <= out_valid_next;
            exp_reg       <= exp_next;
            rcv_reg       <= rcv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg    <= slot_next;
        off_reg     <= off_next;
        payload_reg <= payload_next;
        k_reg       <= k_next;
        c_reg       <= c_next;
        ptail_reg   <= ptail_next;
        lp_ok_reg   <= lp_ok_next;
        len_reg     <= len_next;
        i_reg       <= i_next;
        empty_reg   <= empty_next;
        out_reg     <= out_next;
    end

    // slot buffer memory
    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_reg][slot_wa] <= slot_wd;
        end
        if (slot_re)
        begin
            slot_rd_reg <= slot_mem[slot_reg][slot_ra];
            sv_reg      <= valid_reg[slot_reg][slot_ra];
        end
    end

    // packet ring memory
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[ring_wrow][ring_wa] <= ring_wd;
        end
        if (ring_re)
        begin
            ring_rd_reg <= ring_mem[ring_rrow][ring_ra];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_copy_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cmr_pkg::S_COPY) |-> !full)
        else $error("copy started into a full ring");
    a_empty_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.ring_empty) |-> (out_reg.packet_length == '0))
        else $error("empty marker with nonzero length");
    a_write_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cmr_pkg::S_WRITE) |->
        (k_reg < cmr_pkg::K_W'(cmr_pkg::FRAME_DATA_BYTES)))
        else $error("frame byte counter overran");

endmodule

`default_nettype wire

// ----- tb/sv/cmr_scoreboard.sv -----
// ----------------------------------------------------------------------------
// cmr_scoreboard
// Watches the request, result and register ports of the reassembler, keeps
// its own model of slots and ring, and compares every result byte in order.
// ----------------------------------------------------------------------------
`default_nettype none

module cmr_scoreboard
    import cmr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 in_ready,
    input  wire in_t                  in_data,
    input  wire logic                 out_valid,
    input  wire logic                 out_ready,
    input  wire out_t                 out_data,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    output int                        errors,
    output int                        pending,
    output int                        bytes_checked,
    output int                        packets_stored
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0]      slot_mem [SOURCE_SLOTS][PACKET_BYTES];
    logic [3:0]      frames_due [SOURCE_SLOTS];
    logic [4:0]      frames_got [SOURCE_SLOTS];
    logic [7:0]      ring_mem [RING_DEPTH][PACKET_BYTES];
    int unsigned     wr_ptr, rd_ptr;
    logic [ID_W-1:0] src_id [4];
    logic [2:0]      n_active;
    logic [5:0]      len_pos;
    logic [6:0]      hdr_len, chk_len;
    out_t            byte_queue [$];

    assign pending = byte_queue.size();

    task automatic wipe_slot(input int s);
        for (int k = 0; k < PACKET_BYTES; k++) slot_mem[s][k] = '0;
        frames_due[s] = '0;
        frames_got[s] = '0;
    endtask

    task automatic model_frame(input in_t rq);
        int s;
        int n;
        int off;
        logic [3:0] fidx, fcnt;
        s = -1;
        n = (n_active > SOURCE_SLOTS) ? SOURCE_SLOTS : n_active;
        for (int i = n - 1; i >= 0; i--)
            if (src_id[i] == rq.can_id) s = i;
        if (s < 0) return;
        fidx = rq.frame_header[7:4];
        fcnt = rq.frame_header[3:0];
        if (fidx == 0) begin
            wipe_slot(s);
            frames_due[s] = fcnt;
        end else if (5'(fidx) != frames_got[s]) begin
            wipe_slot(s);
            return;
        end
        off = fidx * FRAME_DATA_BYTES;
        for (int k = 0; k < FRAME_DATA_BYTES; k++)
            if (off + k < PACKET_BYTES) slot_mem[s][off + k] = rq.frame_payload[8*k +: 8];
        frames_got[s] = frames_got[s] + 5'd1;
        if (frames_got[s] != 5'(frames_due[s])) return;
        if ((wr_ptr + 1) % RING_DEPTH != rd_ptr) begin
            for (int k = 0; k < PACKET_BYTES; k++) ring_mem[wr_ptr][k] = slot_mem[s][k];
            wr_ptr = (wr_ptr + 1) % RING_DEPTH;
            packets_stored++;
        end
        wipe_slot(s);
    endtask

    task automatic model_pop();
        out_t r;
        int len;
        logic [7:0] lb;
        if (rd_ptr == wr_ptr) begin
            r = '{packet_byte: 8'd0, packet_length: '0, last_byte: 1'b1, ring_empty: 1'b1};
            byte_queue.push_back(r);
            return;
        end
        lb = (len_pos < PACKET_BYTES) ? ring_mem[rd_ptr][len_pos] : 8'd0;
        len = hdr_len + lb + chk_len;
        if (len > PACKET_BYTES) len = PACKET_BYTES;
        if (len == 0) begin
            r = '{packet_byte: 8'd0, packet_length: '0, last_byte: 1'b1, ring_empty: 1'b0};
            byte_queue.push_back(r);
        end
        for (int i = 0; i < len; i++) begin
            r.packet_byte   = ring_mem[rd_ptr][i];
            r.packet_length = LEN_W'(len);
            r.last_byte     = (i + 1 == len);
            r.ring_empty    = 1'b0;
            byte_queue.push_back(r);
        end
        rd_ptr = (rd_ptr + 1) % RING_DEPTH;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_t want;
        if (!rst_n)
        begin
            for (int s = 0; s < SOURCE_SLOTS; s++) wipe_slot(s);
            for (int i = 0; i < 4; i++) src_id[i] = '0;
            wr_ptr = 0; rd_ptr = 0;
            n_active = 0; len_pos = 1; hdr_len = 4; chk_len = 2;
            errors = 0; bytes_checked = 0; packets_stored = 0;
            byte_queue.delete();
        end
        else
        begin
            if (cfg_we)
                case (cfg_index)
                    REG_SRC_A:   src_id[0] = cfg_data[ID_W-1:0];
                    REG_SRC_B:   src_id[1] = cfg_data[ID_W-1:0];
                    REG_SRC_C:   src_id[2] = cfg_data[ID_W-1:0];
                    REG_SRC_D:   src_id[3] = cfg_data[ID_W-1:0];
                    REG_ACTIVE:  n_active  = cfg_data[2:0];
                    REG_LEN_POS: len_pos   = cfg_data[5:0];
                    REG_HDR:     hdr_len   = cfg_data[6:0];
                    REG_CHK:     chk_len   = cfg_data[6:0];
                    default: ;
                endcase
            if (out_valid && out_ready)
            begin
                if (byte_queue.size() == 0)
                begin
                    errors++;
                    if (errors <= 10) $display("unexpected result %p", out_data);
                end
                else
                begin
                    want = byte_queue.pop_front();
                    bytes_checked++;
                    if (out_data !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected %p, got %p", want, out_data);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (in_data.operation == OP_POP) model_pop();
                else model_frame(in_data);
            end
        end
    end

endmodule

`default_nettype wire

// ----- tb/sv/tb_can_multiframe_reassembler_core.sv -----
// ----------------------------------------------------------------------------
// tb_can_multiframe_reassembler_core
// Drives frames and pops into the reassembler under random stalls and several
// register settings; a separate scoreboard predicts and checks each byte.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_can_multiframe_reassembler_core;
    import cmr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                 clk, rst_n;
    logic                 in_valid, in_ready;
    in_t                  in_data;
    logic                 out_valid, out_ready;
    out_t                 out_data;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    int                   errors, pending, bytes_checked, packets_stored;

    // stimulus bookkeeping
    logic [ID_W-1:0] live_id [4];   // ids currently programmed
    int              live_n;        // effective number of matching slots
    int              requests_sent;
    bit              calm;          // no idling on either side
    bit              hold_req;      // ask the sink for a long hold-off

    can_multiframe_reassembler_core uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    cmr_scoreboard sb (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending),
        .bytes_checked(bytes_checked), .packets_stored(packets_stored)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // hard stop, far beyond the slowest correct run
    initial
    begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // result sink: random stalls, plus one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (600) @(posedge clk);
                hold_req = 1'b0;
            end
            else
                out_ready <= calm || ($urandom_range(99) >= 16);
        end
    end

    // one request: hold valid until it is taken, then maybe idle a while
    task automatic send(input in_t rq);
        in_valid <= 1'b1;
        in_data  <= rq;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        requests_sent++;
        if (!calm && $urandom_range(99) < 16)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic frame(input logic [ID_W-1:0] id, input logic [3:0] fidx,
                         input logic [3:0] fcnt, input logic [55:0] pl);
        in_t rq;
        rq.operation     = OP_RECEIVE;
        rq.can_id        = id;
        rq.frame_header  = {fidx, fcnt};
        rq.frame_payload = pl;
        send(rq);
    endtask

    task automatic pop();
        in_t rq;
        rq.operation     = OP_POP;
        rq.can_id        = ID_W'($urandom);
        rq.frame_header  = 8'($urandom);
        rq.frame_payload = {24'($urandom), 32'($urandom)};
        send(rq);
    endtask

    function automatic logic [55:0] rnd_payload();
        return {24'($urandom), 32'($urandom)};
    endfunction

    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // idle point: all results in, then room for a ring copy still in flight
    task automatic quiesce();
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (200) @(posedge clk);
    endtask

    task automatic program_regs(input int n_act, input logic [5:0] lp, input logic [6:0] hb,
                                input logic [6:0] cb);
        quiesce();
        for (int i = 0; i < 4; i++)
        begin
            live_id[i] = ID_W'($urandom);
            reg_write(REG_SRC_A + CFG_IDX_W'(i), CFG_W'(live_id[i]));
        end
        reg_write(REG_ACTIVE, CFG_W'(n_act));
        reg_write(REG_LEN_POS, CFG_W'(lp));
        reg_write(REG_HDR, CFG_W'(hb));
        reg_write(REG_CHK, CFG_W'(cb));
        cfg_we <= 1'b0;
        @(posedge clk);
        live_n = (n_act > SOURCE_SLOTS) ? SOURCE_SLOTS : n_act;
    endtask

    // a complete, in-order message from one source; the length byte is usually kept small
    task automatic message(input int s, input int nfr);
        logic [55:0] pl;
        for (int f = 0; f < nfr; f++)
        begin
            pl = rnd_payload();
            if ($urandom_range(3) != 0) pl[15:8] = 8'($urandom_range(40));
            frame(live_id[s], 4'(f), 4'(nfr), pl);
        end
    endtask

    task automatic random_phase(input int count);
        int pick, s, nfr;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            s    = (live_n > 0) ? $urandom_range(live_n - 1) : 0;
            nfr  = ($urandom_range(9) == 0) ? $urandom_range(5, 15) : $urandom_range(1, 3);
            if (pick < 50 && live_n > 0)
                message(s, nfr);
            else if (pick < 75)
                pop();
            else if (pick < 85)
                frame(ID_W'($urandom), 4'($urandom), 4'($urandom), rnd_payload());
            else if (live_n > 0)
                // broken or odd header on a known source
                frame(live_id[s], 4'($urandom), 4'($urandom), rnd_payload());
            else
                pop();
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        calm      = 1'b0;
        hold_req  = 1'b0;
        live_n    = 0;
        requests_sent = 0;
        for (int i = 0; i < 4; i++) live_id[i] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults: no source active, so frames are ignored; empty pop
        frame('0, 4'd0, 4'd1, '1);
        pop();

        // directed cases with all four slots
        program_regs(4, 6'd1, 7'd4, 7'd2);
        frame(live_id[0], 4'd0, 4'd1, '1);            // length byte 0xFF saturates
        frame(live_id[1], 4'd0, 4'd2, rnd_payload());
        frame(live_id[1], 4'd1, 4'd2, '0);             // two-frame packet
        frame(live_id[2], 4'd0, 4'd0, rnd_payload());  // count zero never completes
        frame(live_id[2], 4'd3, 4'd0, rnd_payload());  // out of order drops it
        frame(live_id[3], 4'd0, 4'd15, '0);
        frame(live_id[3], 4'd2, 4'd15, '1);            // skipped index
        frame(~live_id[0], 4'd0, 4'd1, '1);            // unknown id
        message(3, 15);                                // high indexes clipped
        pop(); pop(); pop(); pop(); pop();

        // zero computed length, saturated source count
        program_regs(7, 6'd0, 7'd0, 7'd0);
        frame(live_id[0], 4'd0, 4'd1, 56'h0);
        pop();
        frame(live_id[3], 4'd0, 4'd1, 56'h00_0000_0000_0300);
        pop(); pop();

        // ring overflow: complete more packets than fit, then drain
        program_regs(4, 6'd1, 7'd4, 7'd2);
        for (int i = 0; i < 9; i++) message(i % 4, 1);
        for (int i = 0; i < 9; i++) pop();

        // sink holds off while the sender keeps pushing pops
        for (int i = 0; i < 5; i++) message(i % 4, 2);
        hold_req = 1'b1;
        for (int i = 0; i < 8; i++) pop();
        quiesce();  // sender waits for every result

        random_phase(35);
        calm = 1'b1;
        random_phase(10);
        calm = 1'b0;

        program_regs(2, 6'($urandom), 7'd0, 7'd0);
        random_phase(25);

        program_regs(3, 6'd63, 7'd64, 7'd64);
        random_phase(25);

        program_regs(4, 6'd0, 7'($urandom_range(64)), 7'($urandom_range(64)));
        random_phase(20);

        quiesce();
        $display("%0d requests, %0d packets stored, %0d result bytes checked",
                 requests_sent, packets_stored, bytes_checked);
        $display("covered count-zero, out-of-order, unknown ids, ring overflow, long stalls");
        if (errors == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
design/cmr_pkg.sv
design/cmr_front.sv
design/cmr_queue.sv
design/cmr_back.sv
design/can_multiframe_reassembler_core.sv
tb/sv/cmr_scoreboard.sv
tb/sv/tb_can_multiframe_reassembler_core.sv
